@@ hw/rtl/emdt_pkg.sv @@
// Shared types and constants for the multi-turn encoder distance tracker.
`timescale 1ns / 1ps
`default_nettype none

package emdt_pkg;

  localparam int unsigned AngleW = 12;
  localparam int unsigned CountW = 32;
  localparam int unsigned CircW  = 20;
  localparam int unsigned AddrW  = 3;

  // One full turn of the sensor, as counted by the unwrap logic.
  localparam logic [12:0] TurnCounts = 13'd4095;
  // Steps of this magnitude or more are taken as a wrap through zero.
  localparam logic [12:0] WrapLimit  = 13'd2275;
  // Totals above this value clear both totals.
  localparam logic [31:0] ClearLimit = 32'h0FFF_FFFF;
  // count * circumference at or above this makes the length exceed ClearLimit.
  localparam logic [47:0] LengthClearProd = 48'h00FF_F000_0000;

  // Word index of the circumference register on the APB port.
  localparam logic RegIdxCircumference = 1'b0;

  typedef enum logic [1:0] {
    ActSample  = 2'd0,
    ActClear   = 2'd1,
    ActStop    = 2'd2,
    ActRestart = 2'd3
  } action_e;

  typedef enum logic {
    StatusOk      = 1'b0,
    StatusStopped = 1'b1
  } status_e;

endpackage

`default_nettype wire

@@ hw/rtl/encoder_multiturn_distance_tracker.sv @@
// Top level: angle unwrap, running totals and travelled-length pipeline.
// Each accepted input word passes through the p1, p2, p3 and output registers.
// Throughput: one word per cycle while the output is not stalled; the state update (one add,
//   one 28x20 multiply and a compare) completes in the cycle the word is accepted.
// The length (count * circumference / 4095) follows in three more registered stages.
// Reset: asynchronous, active low; totals and circumference clear, tracking is on,
//   no reference angle is held, and the pipeline is emptied.
`timescale 1ns / 1ps
`default_nettype none

module encoder_multiturn_distance_tracker
  import emdt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,   // [11:0] shaft_angle, [15:12] zero
  input  wire logic [1:0]        s_axis_tuser,   // [1:0] action
  // Output stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [63:0]            m_axis_tdata,   // [31:0] angle_total, [63:32] length_total
  output logic                   m_axis_tuser,   // [0] status
  // APB configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------------
  logic p1_valid_q, p2_valid_q, p3_valid_q, out_valid_q;
  logic p1_ready, p2_ready, p3_ready, out_ready;
  logic in_fire;

  assign out_ready = !out_valid_q || m_axis_tready;
  assign p3_ready  = !p3_valid_q || out_ready;
  assign p2_ready  = !p2_valid_q || p3_ready;
  assign p1_ready  = !p1_valid_q || p2_ready;

  assign s_axis_tready = p1_ready;
  assign in_fire       = s_axis_tvalid && p1_ready;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CircW-1:0] circ_q, circ_d;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == RegIdxCircumference);
  assign circ_d    = cfg_write ? pwdata[CircW-1:0] : circ_q;

  always_comb begin
    if (paddr[2] == RegIdxCircumference) begin
      prdata = {{(32 - CircW){1'b0}}, circ_q};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracking state update
  // ---------------------------------------------------------------------------
  action_e            in_action;
  logic [AngleW-1:0]  in_angle;

  logic               have_ref_q, have_ref_d;
  logic               tracking_q, tracking_d;
  logic [AngleW-1:0]  prev_angle_q, prev_angle_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               status_d;

  logic signed [12:0] diff;
  logic [12:0]        mag;
  logic signed [12:0] delta;
  logic [CountW-1:0]  count_sum;
  logic [47:0]        clear_prod;
  logic               clear_hit;

  assign in_action = action_e'(s_axis_tuser);
  assign in_angle  = s_axis_tdata[AngleW-1:0];

  always_comb begin
    diff = $signed({1'b0, in_angle}) - $signed({1'b0, prev_angle_q});
    mag  = diff[12] ? 13'(-diff) : diff;
    if (mag < WrapLimit) begin
      delta = diff;
    end else if (diff[12]) begin
      delta = diff + $signed(TurnCounts);
    end else begin
      delta = diff - $signed(TurnCounts);
    end
    count_sum  = count_q + {{(CountW - 13){delta[12]}}, delta};
    // Only a non-negative count not above the limit reaches the length test.
    clear_prod = count_sum[27:0] * circ_q;
    clear_hit  = !count_sum[31] &&
                 ((count_sum[30:28] != 3'd0) || (clear_prod >= LengthClearProd));
  end

  always_comb begin
    have_ref_d   = have_ref_q;
    tracking_d   = tracking_q;
    prev_angle_d = prev_angle_q;
    count_d      = count_q;
    status_d     = StatusOk;
    if (cfg_write) begin
      count_d = '0;
    end else if (in_fire) begin
      case (in_action)
        ActClear: begin
          count_d = '0;
        end
        ActStop: begin
          tracking_d = 1'b0;
        end
        ActRestart: begin
          have_ref_d = 1'b0;
          tracking_d = 1'b1;
        end
        ActSample: begin
          if (!tracking_q) begin
            status_d = StatusStopped;
          end else if (!have_ref_q) begin
            have_ref_d   = 1'b1;
            prev_angle_d = in_angle;
            count_d      = '0;
          end else begin
            prev_angle_d = in_angle;
            count_d      = clear_hit ? '0 : count_sum;
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q       <= '0;
      have_ref_q   <= 1'b0;
      tracking_q   <= 1'b1;
      prev_angle_q <= '0;
      count_q      <= '0;
    end else begin
      circ_q       <= circ_d;
      have_ref_q   <= have_ref_d;
      tracking_q   <= tracking_d;
      prev_angle_q <= prev_angle_d;
      count_q      <= count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Length pipeline: |count| * circumference, then exact divide by 4095
  // ---------------------------------------------------------------------------
  logic              p1_status_q;
  logic [CountW-1:0] p1_count_q;

  logic              p2_status_q;
  logic [CountW-1:0] p2_count_q;
  logic              p2_neg_q;
  logic [51:0]       p2_prod_q;
  logic [CountW-1:0] p1_abs;

  logic              p3_status_q;
  logic [CountW-1:0] p3_count_q;
  logic              p3_neg_q;
  logic [39:0]       p3_exact_q;
  logic [14:0]       digit_sum;
  logic [12:0]       fold1;
  logic [11:0]       fold2;
  logic [11:0]       rem;

  logic              out_status_q;
  logic [CountW-1:0] out_count_q;
  logic [31:0]       out_length_q;
  logic [39:0]       quot;
  logic [31:0]       length_d;

  assign p1_abs = p1_count_q[31] ? (~p1_count_q + 32'd1) : p1_count_q;

  // Since 4096 = 1 mod 4095, the remainder is the sum of the base-4096 digits.
  always_comb begin
    digit_sum = 15'(p2_prod_q[11:0]) + 15'(p2_prod_q[23:12]) + 15'(p2_prod_q[35:24])
              + 15'(p2_prod_q[47:36]) + 15'(p2_prod_q[51:48]);
    fold1     = 13'(digit_sum[11:0]) + 13'(digit_sum[14:12]);
    fold2     = fold1[11:0] + 12'(fold1[12]);
    rem       = (fold2 >= TurnCounts[11:0]) ? (fold2 - TurnCounts[11:0]) : fold2;
  end

  // The inverse of 4095 modulo 2^40 is -(1 + 2^12 + 2^24 + 2^36), which divides
  // an exact multiple of 4095 without any rounding.
  always_comb begin
    quot = 40'd0 - (p3_exact_q + (p3_exact_q << 12) + (p3_exact_q << 24)
                    + (p3_exact_q << 36));
    if (!p3_neg_q) begin
      length_d = (quot > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
    end else begin
      length_d = (quot > 40'h00_8000_0000) ? 32'h8000_0000 : (32'd0 - quot[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (p1_ready) begin
        p1_valid_q <= s_axis_tvalid;
      end
      if (p2_ready) begin
        p2_valid_q <= p1_valid_q;
      end
      if (p3_ready) begin
        p3_valid_q <= p2_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= p3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p1_status_q <= status_d;
      p1_count_q  <= count_d;
    end
    if (p1_valid_q && p2_ready) begin
      p2_status_q <= p1_status_q;
      p2_count_q  <= p1_count_q;
      p2_neg_q    <= p1_count_q[31];
      p2_prod_q   <= p1_abs * circ_q;
    end
    if (p2_valid_q && p3_ready) begin
      p3_status_q <= p2_status_q;
      p3_count_q  <= p2_count_q;
      p3_neg_q    <= p2_neg_q;
      p3_exact_q  <= p2_prod_q[39:0] - 40'(rem);
    end
    if (p3_valid_q && out_ready) begin
      out_status_q <= p3_status_q;
      out_count_q  <= p3_count_q;
      out_length_q <= length_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_length_q, out_count_q};
  assign m_axis_tuser  = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_clear_zeroes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_action == ActClear) |=> (p1_count_q == '0))
    else $error("clear action did not zero the count");

  a_stopped_sample_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_action == ActSample && !tracking_q) |=>
      (p1_status_q == StatusStopped && !tracking_q && $stable(count_q)))
    else $error("sample while stopped changed state or missed its flag");

  a_count_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(!m_axis_tdata[31] && (m_axis_tdata[31:0] > ClearLimit)))
    else $error("reported count above the clear limit");

  a_empty_output_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled while the output stage is empty");

endmodule

`default_nettype wire
